### rtl/delay_sigma_aqm_marker_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delay sigma marker
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DELAY_SIGMA_AQM_MARKER_TOP_MACROS_SVH
`define DELAY_SIGMA_AQM_MARKER_TOP_MACROS_SVH

// Check that a property holds at every clock edge outside reset
`define DSAM_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Check that a condition never occurs outside reset
`define DSAM_ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

### rtl/dsam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delay sigma marker package
// Widths, constants, state encodings and shared types of the marker.
// ----------------------------------------------------------------------------
package dsam_pkg;

   // Field and datapath widths
   localparam int TIME_W      = 63;
   localparam int SOJ_W       = 40;
   localparam int CFG_W       = 32;
   localparam int DIFF_W      = SOJ_W + 1;
   localparam int INTERVAL_W  = 30;
   localparam int WORD_W      = 64;
   localparam int HALF_W      = WORD_W / 2;
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_INDEX_W = 1;

   // Loop arithmetic
   localparam int GAIN_FRACTION_BITS = 16;
   localparam int DECAY_SHIFT        = 4;
   localparam logic [WORD_W-1:0]     ONE_SECOND_NS  = 64'd1000000000;
   localparam logic [WORD_W-1:0]     TWO_SECONDS_NS = 64'd2000000000;
   localparam logic [INTERVAL_W-1:0] ONE_SECOND_IV  = 30'd1000000000;

   // Register reset values
   localparam logic [CFG_W-1:0] DELAY_TARGET_RESET  = 32'd5000000;
   localparam logic [CFG_W-1:0] RESONANT_GAIN_RESET = 32'd2621440;

   // Queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // Radix-16 divider by one second
   localparam int DIV_RADIX  = 4;
   localparam int DIV_TAIL_W = 36;
   localparam int DIV_QUO_W  = DIV_TAIL_W;
   localparam int DIV_REM_W  = INTERVAL_W;
   localparam int DIV_STEPS  = DIV_TAIL_W / DIV_RADIX;
   localparam int DIV_CNT_W  = 4;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DELAY_TARGET  = 1'b0,
      CSR_RESONANT_GAIN = 1'b1
   } csr_index_type;

   // One classified packet, as queued for the back end
   typedef struct packed {
      logic                  osc_en;
      logic                  clear;
      logic [INTERVAL_W-1:0] interval;
      logic [DIFF_W-1:0]     delta;
      logic [DIFF_W-1:0]     err;
   } dsam_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_RUN,
      DV_FIN
   } div_state_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MUL_LO,
      BK_MUL_HI,
      BK_MUL_SUM,
      BK_DIV_GO,
      BK_DIV_WAIT,
      BK_ACC,
      BK_PHASE,
      BK_WRAP,
      BK_DONE
   } back_state_type;

   // Which product the shared multiplier is forming
   typedef enum logic [1:0] {
      PROD_SIGMA,
      PROD_ACCUM,
      PROD_OSC,
      PROD_STEP
   } prod_sel_type;

endpackage

### rtl/delay_sigma_aqm_marker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delay sigma marker
// Delay-driven congestion marker: delta-sigma loop and phase oscillator.
// ----------------------------------------------------------------------------
// The req channel takes one transaction per dequeued packet (time_now and
// sojourn_time); the rsp channel returns one transaction per packet with the
// mark bit, in order. The csr port writes delay_target (index 0) and
// resonant_gain (index 1); the user is to write them only while the block
// is idle, as the block itself does not enforce this. The front end
// accepts and classifies a packet in the cycle it arrives and places it in a
// four-entry queue; the back end then runs the update with one shared 32x32
// multiplier (low half, high half and sum steps per 64-bit product) and a
// radix-16 divider by one second. In the back end a packet whose sojourn is
// below half the target needs two products and one division; any other
// needs four products and two divisions. The back end takes the next packet
// from the queue only once it has finished the last, while the queue goes on
// accepting new packets.
// Reset clears the integrators, the previous time and sojourn, the queue
// and the result slot, and loads the register reset values. A stalled rsp
// holds its result; the back end waits after finishing the next packet, and
// req_tready falls only once the queue is full.
// ----------------------------------------------------------------------------
module delay_sigma_aqm_marker_top
   import dsam_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [62:0] time_now, [102:63] sojourn_time, [103] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] mark_packet, [7:1] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   logic [CFG_W-1:0] delay_target_ff, delay_target_in;
   logic [CFG_W-1:0] resonant_gain_ff, resonant_gain_in;
   fifo_status_type  fifo_status;
   logic             push;
   logic             pop;
   dsam_entry_type   push_entry;
   dsam_entry_type   pop_entry;
   div_req_type      div_req;
   div_rsp_type      div_rsp;
   logic             rsp_mark;

   // Decode register writes
   always_comb begin
      delay_target_in  = delay_target_ff;
      resonant_gain_in = resonant_gain_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DELAY_TARGET:  delay_target_in  = csr_wdata;
            CSR_RESONANT_GAIN: resonant_gain_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_target_ff  <= DELAY_TARGET_RESET;
         resonant_gain_ff <= RESONANT_GAIN_RESET;
      end else begin
         delay_target_ff  <= delay_target_in;
         resonant_gain_ff <= resonant_gain_in;
      end
   end

   dsam_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_time     (req_tdata[TIME_W-1:0]),
      .req_soj      (req_tdata[TIME_W+SOJ_W-1:TIME_W]),
      .delay_target (delay_target_ff),
      .fifo_status  (fifo_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   dsam_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_entry  (push_entry),
      .pop         (pop),
      .pop_entry   (pop_entry),
      .fifo_status (fifo_status)
   );

   dsam_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   dsam_back u_back (
      .clock         (clock),
      .reset         (reset),
      .resonant_gain (resonant_gain_ff),
      .fifo_status   (fifo_status),
      .pop           (pop),
      .pop_entry     (pop_entry),
      .div_req       (div_req),
      .div_rsp       (div_rsp),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_mark      (rsp_mark)
   );

   assign rsp_tdata = {(RSP_TDATA_W - 1)'(0), rsp_mark};

endmodule

### rtl/dsam_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delay sigma marker front end
// Accepts packets, forms the interval and sojourn differences and queues them.
// ----------------------------------------------------------------------------
module dsam_front
   import dsam_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [TIME_W-1:0]    req_time,
   input  logic [SOJ_W-1:0]     req_soj,
   input  logic [CFG_W-1:0]     delay_target,
   input  fifo_status_type      fifo_status,
   output logic                 push,
   output dsam_entry_type       push_entry
);

   logic [TIME_W-1:0] prev_time_ff, prev_time_in;
   logic [SOJ_W-1:0]  prev_soj_ff, prev_soj_in;
   logic [WORD_W-1:0] interval_full;
   logic              long_gap;
   logic              below_target;

   // Take a transaction whenever the queue has room
   assign req_ready = !fifo_status.full;
   assign push      = req_valid && req_ready;

   // Classify the gap since the previous packet
   assign interval_full = {1'b0, req_time} - {1'b0, prev_time_ff};
   assign long_gap      = interval_full > ONE_SECOND_NS;
   assign below_target  = req_soj < SOJ_W'(delay_target);

   always_comb begin
      push_entry.clear    = long_gap && below_target;
      push_entry.interval = interval_full[INTERVAL_W-1:0];
      if (long_gap) begin
         push_entry.interval = below_target ? '0 : ONE_SECOND_IV;
      end
      push_entry.delta  = {1'b0, req_soj} - {1'b0, prev_soj_ff};
      push_entry.err    = {1'b0, req_soj} - DIFF_W'(delay_target);
      push_entry.osc_en = {req_soj, 1'b0} >= DIFF_W'(delay_target);
   end

   // Remember the last accepted packet
   always_comb begin
      prev_time_in = prev_time_ff;
      prev_soj_in  = prev_soj_ff;
      if (push) begin
         prev_time_in = req_time;
         prev_soj_in  = req_soj;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
         prev_soj_ff  <= '0;
      end else begin
         prev_time_ff <= prev_time_in;
         prev_soj_ff  <= prev_soj_in;
      end
   end

endmodule

### rtl/dsam_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delay sigma marker queue
// Four-entry queue of classified packets between front and back end.
// ----------------------------------------------------------------------------
`include "delay_sigma_aqm_marker_top_macros.svh"

module dsam_fifo
   import dsam_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  dsam_entry_type  push_entry,
   input  logic            pop,
   output dsam_entry_type  pop_entry,
   output fifo_status_type fifo_status
);

   dsam_entry_type        mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry         = mem_ff[rd_ptr_ff];
   assign fifo_status.empty = count_ff == '0;
   assign fifo_status.full  = count_ff == FIFO_CNT_W'(FIFO_DEPTH);

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `DSAM_ASSERT_NEVER(a_push_full, clock, reset, push && fifo_status.full, "push into full queue")
   `DSAM_ASSERT_NEVER(a_pop_empty, clock, reset, pop && fifo_status.empty, "pop from empty queue")
   `DSAM_ASSERT(a_ptr_count, clock, reset, (wr_ptr_ff - rd_ptr_ff) == count_ff[FIFO_PTR_W-1:0], "queue pointers disagree with count")
   `DSAM_ASSERT(a_count_max, clock, reset, count_ff <= FIFO_CNT_W'(FIFO_DEPTH), "queue count beyond depth")

endmodule

### rtl/dsam_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delay sigma marker divider
// Signed division by one second, truncating toward zero, four bits a cycle.
// ----------------------------------------------------------------------------
module dsam_div
   import dsam_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   div_state_type          state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic [DIV_REM_W-1:0]   rem_ff, rem_in;
   logic [DIV_TAIL_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_QUO_W-1:0]   quo_ff, quo_in;
   logic                   done_ff, done_in;
   logic [WORD_W-1:0]      q_ff, q_in;
   logic [WORD_W-1:0]      mag;
   logic [DIV_REM_W-1:0]   step_rem;
   logic [DIV_RADIX-1:0]   step_bits;

   // Magnitude of the dividend
   assign mag = div_req.dividend[WORD_W-1] ? WORD_W'(0) - div_req.dividend
                                           : div_req.dividend;

   // Four restoring steps against one second
   always_comb begin : radix_step
      logic [DIV_REM_W:0]   trial;
      logic [DIV_REM_W-1:0] rem;
      rem       = rem_ff;
      step_bits = '0;
      for (int i = 0; i < DIV_RADIX; i++) begin
         trial = {rem, dvd_ff[DIV_TAIL_W-1-i]};
         if (trial >= {1'b0, ONE_SECOND_IV}) begin
            rem = DIV_REM_W'(trial - {1'b0, ONE_SECOND_IV});
            step_bits[DIV_RADIX-1-i] = 1'b1;
         end else begin
            rem = trial[DIV_REM_W-1:0];
         end
      end
      step_rem = rem;
   end

   // Sequence load, iterate and sign fix-up
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         DV_IDLE: begin
            if (div_req.start) begin
               neg_in   = div_req.dividend[WORD_W-1];
               rem_in   = DIV_REM_W'(mag[WORD_W-1:DIV_TAIL_W]);
               dvd_in   = mag[DIV_TAIL_W-1:0];
               quo_in   = '0;
               cnt_in   = '0;
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            rem_in = step_rem;
            dvd_in = dvd_ff << DIV_RADIX;
            quo_in = {quo_ff[DIV_QUO_W-DIV_RADIX-1:0], step_bits};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = DV_FIN;
            end
         end
         DV_FIN: begin
            q_in     = neg_ff ? WORD_W'(0) - WORD_W'(quo_ff) : WORD_W'(quo_ff);
            done_in  = 1'b1;
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      q_ff   <= q_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = q_ff;

endmodule

### rtl/dsam_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delay sigma marker back end
// Runs the accumulator and oscillator update for each queued packet.
// ----------------------------------------------------------------------------
`include "delay_sigma_aqm_marker_top_macros.svh"

module dsam_back
   import dsam_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [CFG_W-1:0] resonant_gain,
   input  fifo_status_type fifo_status,
   output logic            pop,
   input  dsam_entry_type  pop_entry,
   output div_req_type     div_req,
   input  div_rsp_type     div_rsp,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic            rsp_mark
);

   back_state_type        state_ff, state_in;
   prod_sel_type          step_ff, step_in;
   logic [WORD_W-1:0]     mul_a_ff, mul_a_in;
   logic [HALF_W-1:0]     mul_b_ff, mul_b_in;
   logic [WORD_W-1:0]     mul_ff, mul_in;
   logic [WORD_W-1:0]     prod_ff, prod_in;
   logic [WORD_W-1:0]     accum_ff, accum_in;
   logic [WORD_W-1:0]     phase_ff, phase_in;
   logic                  mark_ff, mark_in;
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [DIFF_W-1:0]     delta_ff, delta_in;
   logic                  osc_en_ff, osc_en_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_mark_ff, rsp_mark_in;

   logic [HALF_W-1:0]     mul_half;
   logic [WORD_W-1:0]     mul_full;
   logic [WORD_W-1:0]     prod_shr;
   logic [WORD_W-1:0]     acc_sum;
   logic [WORD_W-1:0]     phase_sum;
   logic [WORD_W-1:0]     decay;
   logic                  wrap;
   logic                  over;

   function automatic logic [WORD_W-1:0] sext_diff(input logic [DIFF_W-1:0] v);
      return {{(WORD_W - DIFF_W){v[DIFF_W-1]}}, v};
   endfunction

   // Shared 32x32 multiplier, low half first
   assign mul_half = (state_ff == BK_MUL_HI) ? mul_a_ff[WORD_W-1:HALF_W]
                                             : mul_a_ff[HALF_W-1:0];
   assign mul_full = mul_half * mul_b_ff;

   // Accumulator and phase arithmetic
   assign prod_shr  = WORD_W'($signed(prod_ff) >>> GAIN_FRACTION_BITS);
   assign acc_sum   = accum_ff + prod_shr;
   assign phase_sum = phase_ff + prod_shr;
   assign decay     = WORD_W'($signed(accum_ff) >>> DECAY_SHIFT);
   assign wrap      = !phase_ff[WORD_W-1] && (phase_ff >= ONE_SECOND_NS);
   assign over      = !phase_ff[WORD_W-1] && (phase_ff > TWO_SECONDS_NS);

   assign div_req.start    = state_ff == BK_DIV_GO;
   assign div_req.dividend = prod_ff;

   // Sequence the products, divisions and state updates of one packet
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      mul_in       = mul_ff;
      prod_in      = prod_ff;
      accum_in     = accum_ff;
      phase_in     = phase_ff;
      mark_in      = mark_ff;
      interval_in  = interval_ff;
      delta_in     = delta_ff;
      osc_en_in    = osc_en_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mark_in  = rsp_mark_ff;
      pop          = 1'b0;

      // Drop the result once the transaction completes
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         BK_IDLE: begin
            if (!fifo_status.empty) begin
               pop         = 1'b1;
               interval_in = pop_entry.interval;
               delta_in    = pop_entry.delta;
               osc_en_in   = pop_entry.osc_en;
               mark_in     = 1'b0;
               if (pop_entry.clear) begin
                  accum_in = '0;
               end
               mul_a_in = sext_diff(pop_entry.err);
               mul_b_in = HALF_W'(pop_entry.interval);
               step_in  = PROD_SIGMA;
               state_in = BK_MUL_LO;
            end
         end
         BK_MUL_LO: begin
            mul_in   = mul_full;
            state_in = BK_MUL_HI;
         end
         BK_MUL_HI: begin
            prod_in  = mul_ff;
            mul_in   = mul_full;
            state_in = BK_MUL_SUM;
         end
         BK_MUL_SUM: begin
            prod_in = prod_ff + {mul_ff[HALF_W-1:0], HALF_W'(0)};
            unique case (step_ff) inside
               PROD_SIGMA, PROD_OSC: state_in = BK_DIV_GO;
               PROD_ACCUM:           state_in = BK_ACC;
               PROD_STEP:            state_in = BK_PHASE;
            endcase
         end
         BK_DIV_GO: begin
            state_in = BK_DIV_WAIT;
         end
         BK_DIV_WAIT: begin
            if (div_rsp.done) begin
               mul_b_in = resonant_gain;
               state_in = BK_MUL_LO;
               if (step_ff == PROD_SIGMA) begin
                  mul_a_in = sext_diff(delta_ff) + div_rsp.quotient;
                  step_in  = PROD_ACCUM;
               end else begin
                  mul_a_in = div_rsp.quotient;
                  step_in  = PROD_STEP;
               end
            end
         end
         BK_ACC: begin
            // A negative accumulator restarts both integrators
            if (acc_sum[WORD_W-1]) begin
               accum_in = '0;
               phase_in = '0;
               mul_a_in = '0;
            end else begin
               accum_in = acc_sum;
               mul_a_in = acc_sum;
            end
            mul_b_in = HALF_W'(interval_ff);
            step_in  = PROD_OSC;
            state_in = osc_en_ff ? BK_MUL_LO : BK_DONE;
         end
         BK_PHASE: begin
            phase_in = phase_sum;
            state_in = BK_WRAP;
         end
         BK_WRAP: begin
            // Mark on a wrap past one second, decay when still beyond it
            mark_in = wrap;
            if (wrap) begin
               phase_in = phase_ff - ONE_SECOND_NS;
            end
            if (over) begin
               accum_in = accum_ff - decay;
            end
            state_in = BK_DONE;
         end
         BK_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_mark_in  = mark_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         accum_ff     <= '0;
         phase_ff     <= '0;
         mark_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         accum_ff     <= accum_in;
         phase_ff     <= phase_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff     <= step_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      mul_ff      <= mul_in;
      prod_ff     <= prod_in;
      interval_ff <= interval_in;
      delta_ff    <= delta_in;
      osc_en_ff   <= osc_en_in;
      rsp_mark_ff <= rsp_mark_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_mark   = rsp_mark_ff;

   `DSAM_ASSERT(a_div_wait, clock, reset, div_rsp.done |-> state_ff == BK_DIV_WAIT, "divider result while not waiting")
   `DSAM_ASSERT_NEVER(a_accum_neg, clock, reset, accum_ff[WORD_W-1], "accumulator left negative")
   `DSAM_ASSERT(a_mark_src, clock, reset, $rose(mark_ff) |-> $past(state_ff == BK_WRAP), "mark set outside wrap check")

endmodule
